// ----- design/delimiter_stream_splitter_macros.svh -----
// Assertion macros shared by the delimiter stream splitter modules.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef DELIMITER_STREAM_SPLITTER_MACROS_SVH
`define DELIMITER_STREAM_SPLITTER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define DSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/dss_pkg.sv -----
// Shared types and constants for the delimiter stream splitter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package dss_pkg;

  localparam int DELIM_MAX  = 8;
  // Longest delimiter the compare can use.
  localparam int LEN_CAP    = (DELIM_MAX < 8) ? DELIM_MAX : 8;
  // At most one result from the compare plus a full flush and its token end.
  localparam int RES_MAX    = LEN_CAP + 1;
  // Width for fill levels, lengths and result counts (up to LEN_CAP + 1).
  localparam int CNT_W      = $clog2(LEN_CAP + 2);

  localparam int BYTE_W     = 8;
  localparam int DELIM_W    = 64;
  localparam int LEN_REG_W  = 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = CFG_IDX_W'(1);

  typedef struct packed {
    logic [BYTE_W-1:0] token_byte;
    logic              byte_valid;
    logic              token_end;
  } result_t;

  // All results caused by one input item, in delivery order from entry 0.
  typedef struct packed {
    result_t [RES_MAX-1:0] entries;
    logic [CNT_W-1:0]      count;
  } job_t;

endpackage

// ----- design/dss_window.sv -----
// Input register, match window and delimiter compare of the splitter.
// Depends on dss_pkg; hands a finished job of results to dss_result_queue.
`timescale 1ns / 1ps
`include "delimiter_stream_splitter_macros.svh"

module dss_window import dss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid_s,
  output logic                 in_ready_s,
  input  logic [BYTE_W-1:0]    in_byte,
  input  logic                 in_last,
  input  logic [DELIM_W-1:0]   delim_bytes,
  input  logic [LEN_REG_W-1:0] delim_length,
  output logic                 job_valid,
  input  logic                 job_take,
  output job_t                 job
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_reg_byte;
  logic              in_reg_last;

  logic [BYTE_W-1:0] window [LEN_CAP];
  logic [CNT_W-1:0]  fill;

  logic [BYTE_W-1:0] win_wr  [LEN_CAP];
  logic [BYTE_W-1:0] win_ext [RES_MAX+1];
  logic [BYTE_W-1:0] window_next [LEN_CAP];
  logic [CNT_W-1:0]  fill_next;
  logic [CNT_W-1:0]  eff_len;
  logic [CNT_W-1:0]  new_fill;
  logic              full;
  logic              eq;
  logic              flush;

  assign in_ready_s = !in_valid || job_take;
  assign job_valid  = in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready_s) begin
      in_valid <= in_valid_s;
    end
    if (in_ready_s && in_valid_s) begin
      in_reg_byte <= in_byte;
      in_reg_last <= in_last;
    end
  end

  // Zero length acts as one; lengths beyond the window are clipped.
  always_comb begin
    if (delim_length == LEN_REG_W'(0)) begin
      eff_len = CNT_W'(1);
    end else if (delim_length > LEN_REG_W'(LEN_CAP)) begin
      eff_len = CNT_W'(LEN_CAP);
    end else begin
      eff_len = CNT_W'(delim_length);
    end
  end

  always_comb begin
    int jm;
    new_fill = fill + CNT_W'(1);
    full     = (new_fill == eff_len);

    for (int i = 0; i < LEN_CAP; i++) begin
      win_wr[i] = (fill == CNT_W'(i)) ? in_reg_byte : window[i];
    end

    eq = 1'b1;
    for (int i = 0; i < LEN_CAP; i++) begin
      if ((CNT_W'(i) < eff_len) && (win_wr[i] != delim_bytes[BYTE_W*i +: BYTE_W])) begin
        eq = 1'b0;
      end
    end

    // On a mismatch the oldest byte leaves and the rest move down one place.
    for (int i = 0; i < RES_MAX + 1; i++) begin
      win_ext[i] = '0;
    end
    for (int i = 0; i < LEN_CAP; i++) begin
      if (full && !eq) begin
        win_ext[i] = (i + 1 < LEN_CAP) ? win_wr[(i + 1) % LEN_CAP] : win_wr[i];
      end else begin
        win_ext[i] = win_wr[i];
      end
    end
    for (int i = 0; i < LEN_CAP; i++) begin
      window_next[i] = win_ext[i];
    end

    if (full) begin
      fill_next = eq ? '0 : eff_len - CNT_W'(1);
    end else begin
      fill_next = new_fill;
    end

    // The last byte flushes what stays in the window unless it closed a match.
    flush = in_reg_last && !(full && eq);

    job.count = (full ? CNT_W'(1) : CNT_W'(0)) +
                (flush ? fill_next + CNT_W'(1) : CNT_W'(0));

    for (int j = 0; j < RES_MAX; j++) begin
      jm = full ? ((j == 0) ? 0 : j - 1) : j;
      if (full && (j == 0)) begin
        job.entries[j].token_byte = eq ? '0 : win_wr[0];
        job.entries[j].byte_valid = !eq;
        job.entries[j].token_end  = eq;
      end else if (CNT_W'(jm) < fill_next) begin
        job.entries[j].token_byte = win_ext[jm];
        job.entries[j].byte_valid = 1'b1;
        job.entries[j].token_end  = 1'b0;
      end else begin
        job.entries[j].token_byte = '0;
        job.entries[j].byte_valid = 1'b0;
        job.entries[j].token_end  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (job_take) begin
      fill <= in_reg_last ? '0 : fill_next;
    end
    if (job_take) begin
      window <= window_next;
    end
  end

  `DSS_ASSERT_NEXT(a_last_clears_fill, job_take && in_reg_last, fill == '0, "fill not cleared after last byte")

endmodule

// ----- design/dss_result_queue.sv -----
// Result queue that delivers the results of one item, one per cycle while m_tready is high.
// Depends on dss_pkg; fed by dss_window, drives the master-side stream.
`timescale 1ns / 1ps
`include "delimiter_stream_splitter_macros.svh"

module dss_result_queue import dss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_take,
  input  job_t              job,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [BYTE_W-1:0] m_tdata,   // token_byte
  output logic              m_tlast,   // token_end
  output logic [1:0]        m_tuser    // bit 0: byte_valid, bit 1: last_result
);

  result_t          queue [RES_MAX];
  logic [CNT_W-1:0] count;
  logic             pop;
  logic             can_load;

  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid && m_tready;
  assign can_load = (count == '0) || ((count == CNT_W'(1)) && pop);
  assign job_take = job_valid && can_load;

  assign m_tdata  = queue[0].token_byte;
  assign m_tlast  = queue[0].token_end;
  assign m_tuser  = {count == CNT_W'(1), queue[0].byte_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (job_take) begin
      count <= job.count;
    end else if (pop) begin
      count <= count - CNT_W'(1);
    end
    if (job_take) begin
      for (int i = 0; i < RES_MAX; i++) begin
        queue[i] <= job.entries[i];
      end
    end else if (pop) begin
      for (int i = 0; i < RES_MAX - 1; i++) begin
        queue[i] <= queue[i + 1];
      end
    end
  end

  `DSS_ASSERT(a_count_bound, count <= CNT_W'(RES_MAX), "result count beyond queue depth")
  `DSS_ASSERT_NEXT(a_pop_decrements, pop && !job_take, count == $past(count) - CNT_W'(1), "queue count did not step down")
  `DSS_ASSERT(a_end_has_no_byte, !(m_tvalid && m_tlast && m_tuser[0]), "token end carries a byte")

endmodule

// ----- design/delimiter_stream_splitter.sv -----
// Top level of the delimiter stream splitter: configuration registers and busy flag.
// Depends on dss_pkg, dss_window and dss_result_queue.
`timescale 1ns / 1ps

// Usage:
// The slave-side stream takes one string byte per item in s_tdata, with s_tlast
// set on the final byte of the string. The master-side stream returns results:
// m_tdata is a token byte, m_tuser[0] says that the byte is valid, m_tlast marks
// a token end (which carries no byte), and m_tuser[1] flags the final result
// caused by one input item.
// The delimiter (bytes and length) is written over the cfg port while no string
// is in progress; writes during a string are dropped, and cfg_ready is always high.
// An accepted byte passes the input register, then the result queue. One input item
// is taken per cycle while it causes at most one result and the receiver accepts;
// the last byte of a string can cause up to the delimiter length plus one results,
// which leave the queue one per cycle when accepted, while the input side waits.
// When the receiver stalls, the result queue holds its head item, and s_tready
// drops once the input register is also occupied.
// Reset empties the window and the queue, clears the busy flag and sets a
// one-byte delimiter of value zero.
module delimiter_stream_splitter import dss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,    // data_byte
  input  logic                 s_tlast,    // last_byte
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [BYTE_W-1:0]    m_tdata,    // token_byte
  output logic                 m_tlast,    // token_end
  output logic [1:0]           m_tuser,    // bit 0: byte_valid, bit 1: last_result
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DELIM_W-1:0]   cfg_data
);

  logic [DELIM_W-1:0]   delim_bytes;
  logic [LEN_REG_W-1:0] delim_length;
  logic                 busy;
  logic                 job_valid;
  logic                 job_take;
  job_t                 job;

  assign cfg_ready = 1'b1;

  // A string counts as in progress from its first accepted byte until its last.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      busy <= !s_tlast;
    end
  end

  // Register writes only land between strings; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      delim_bytes  <= '0;
      delim_length <= LEN_REG_W'(1);
    end else if (cfg_valid && cfg_ready && !busy) begin
      unique case (cfg_index)
        REG_DELIM_BYTES:  delim_bytes  <= cfg_data;
        REG_DELIM_LENGTH: delim_length <= cfg_data[LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  dss_window u_window (
    .clk          (clk),
    .rst          (rst),
    .in_valid_s   (s_tvalid),
    .in_ready_s   (s_tready),
    .in_byte      (s_tdata),
    .in_last      (s_tlast),
    .delim_bytes  (delim_bytes),
    .delim_length (delim_length),
    .job_valid    (job_valid),
    .job_take     (job_take),
    .job          (job)
  );

  dss_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule
